// ----- rtl/erm_pkg.sv -----
// ----------------------------------------------------------------------------
// erm_pkg
// Types and constants shared by the event rule matcher files.
// ----------------------------------------------------------------------------
package erm_pkg;

  localparam logic [15:0] COOLDOWN_RESET = 16'd100;
  localparam int          RESULT_LIMIT   = 16;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_REMOVE = 3'd1,
    OP_READ   = 3'd2,
    OP_STATE  = 3'd3,
    OP_SWITCH = 3'd4,
    OP_TAKE   = 3'd5
  } op_t;

  typedef enum logic [3:0] {
    ST_ADDED     = 4'd0,
    ST_INVALID   = 4'd1,
    ST_FULL      = 4'd2,
    ST_REMOVED   = 4'd3,
    ST_READ_OK   = 4'd4,
    ST_READ_NONE = 4'd5,
    ST_QUEUED    = 4'd6,
    ST_SKIP      = 4'd7,
    ST_QFULL     = 4'd8,
    ST_NO_MATCH  = 4'd9,
    ST_FIRED     = 4'd10,
    ST_VANISHED  = 4'd11,
    ST_QEMPTY    = 4'd12,
    ST_UNKNOWN   = 4'd13
  } status_t;

  // Trigger codes
  localparam logic [2:0] TRG_ACTIVE   = 3'd0;
  localparam logic [2:0] TRG_ALERT    = 3'd1;
  localparam logic [2:0] TRG_CRITICAL = 3'd2;
  localparam logic [2:0] TRG_IDLE     = 3'd3;
  localparam logic [2:0] TRG_LOST     = 3'd4;
  localparam logic [2:0] TRG_SW_ON    = 3'd5;
  localparam logic [2:0] TRG_SW_OFF   = 3'd6;

  // State event values
  localparam logic [2:0] EV_IDLE     = 3'd0;
  localparam logic [2:0] EV_ACTIVE   = 3'd1;
  localparam logic [2:0] EV_ALERT    = 3'd2;
  localparam logic [2:0] EV_CRITICAL = 3'd3;
  localparam logic [2:0] EV_LOST     = 3'd4;

  typedef enum logic [1:0] {
    FSM_IDLE  = 2'd0,
    FSM_SCAN  = 2'd1,
    FSM_FLUSH = 2'd2
  } fsm_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [3:0]  slot_index;
    logic [7:0]  node_index;
    logic        node_known;
    logic [2:0]  event_value;
    logic [31:0] now_ms;
    logic [7:0]  new_node;
    logic [2:0]  new_trigger;
    logic [1:0]  new_action;
    logic [3:0]  new_target_count;
  } in_t;

  typedef struct packed {
    logic [3:0] status;
    logic [3:0] rule_slot;
    logic [7:0] rule_node;
    logic [2:0] rule_trigger;
    logic [1:0] rule_action;
    logic [3:0] rule_target_count;
    logic [4:0] active_rules;
    logic       last_result;
  } out_t;

  // Command broadcast to every cell
  typedef struct packed {
    logic        shift;
    logic        launch;
    logic        add_en;
    logic        rm_en;
    logic        stamp_en;
    logic [31:0] stamp_val;
    logic [7:0]  node;
    logic [2:0]  trig;
    logic [1:0]  act;
    logic [3:0]  cnt;
  } cmd_t;

  // Contents of one cell
  typedef struct packed {
    logic        valid;
    logic [7:0]  node;
    logic [2:0]  trig;
    logic [1:0]  act;
    logic [3:0]  cnt;
    logic [31:0] last;
  } view_t;

endpackage

// ----- rtl/erm_cell.sv -----
// ----------------------------------------------------------------------------
// erm_cell
// One rule slot: holds the rule and its fire stamp, passes the scan token
// and the free-slot chain to its neighbor.
// ----------------------------------------------------------------------------
module erm_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  erm_pkg::cmd_t  cmd,
  input  logic           sel,
  input  logic           tok_in,
  input  logic           seen_in,
  output logic           tok,
  output logic           seen_out,
  output logic           claim,
  output erm_pkg::view_t view
);

  erm_pkg::view_t rule_r, rule_nxt;
  logic           tok_r, tok_nxt;

  // free chain: first empty cell claims an add
  assign claim    = !seen_in && !rule_r.valid;
  assign seen_out = seen_in || !rule_r.valid;
  assign tok      = tok_r;
  assign view     = rule_r;

  always_comb begin
    rule_nxt = rule_r;
    tok_nxt  = cmd.shift ? tok_in : 1'b0;
    if (cmd.add_en && claim) begin
      rule_nxt.valid = 1'b1;
      rule_nxt.node  = cmd.node;
      rule_nxt.trig  = cmd.trig;
      rule_nxt.act   = cmd.act;
      rule_nxt.cnt   = cmd.cnt;
    end
    if (cmd.rm_en && sel) begin
      rule_nxt = '0;
    end
    if (cmd.stamp_en && tok_r) begin
      rule_nxt.last = cmd.stamp_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_r <= '0;
      tok_r  <= 1'b0;
    end else begin
      rule_r <= rule_nxt;
      tok_r  <= tok_nxt;
    end
  end

endmodule

// ----- rtl/erm_fifo.sv -----
// ----------------------------------------------------------------------------
// erm_fifo
// Fire queue of slot numbers, circular buffer with fill count.
// ----------------------------------------------------------------------------
module erm_fifo #(
  parameter int DEPTH = 8,
  parameter int W     = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         full,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [FW-1:0] fill_r, fill_nxt;

  assign full     = (fill_r == FW'(DEPTH));
  assign empty    = (fill_r == '0);
  assign pop_data = mem_r[head_r];

  // pointer and fill update
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    fill_nxt = fill_r;
    if (push) begin
      tail_nxt = (tail_r == PW'(DEPTH - 1)) ? '0 : tail_r + 1'b1;
      fill_nxt = fill_nxt + 1'b1;
    end
    if (pop) begin
      head_nxt = (head_r == PW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
      fill_nxt = fill_nxt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      fill_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[tail_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("fire queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("fire queue pop while empty");
  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (fill_r == $past(fill_r) + 1'b1))
    else $error("fire queue fill did not advance");

endmodule

// ----- rtl/event_rule_match_cooldown.sv -----
// ----------------------------------------------------------------------------
// event_rule_match_cooldown
// Rule table with per-rule fire stamps, one shared cooldown and a fire queue, built as a row of cells.
// ----------------------------------------------------------------------------
// Add, remove, read, take, invalid and unknown-node items: one result, in the
//   cycle after start is accepted; busy stays low.
// Known-node state and switch events: a token walks the cell row one slot
//   per cycle, then a flush state flags the last result; busy is high meanwhile.
// Synchronous active-low reset clears the table, stamps, queue and sets
//   cooldown_ms to 100; results are shown one cycle each, no stall.
module event_rule_match_cooldown #(
  parameter int RULE_SLOTS  = 16,
  parameter int QUEUE_DEPTH = 8,
  parameter int MAX_TARGETS = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  erm_pkg::in_t  in_data,
  output logic          out_valid,
  output erm_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [15:0]   cfg_wdata
);

  localparam int SW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int AW = $clog2(RULE_SLOTS + 1);
  localparam int KW = $clog2(erm_pkg::RESULT_LIMIT + 1);

  erm_pkg::fsm_t  state_r, state_nxt;
  erm_pkg::cmd_t  cmd;
  erm_pkg::view_t views [RULE_SLOTS];
  erm_pkg::view_t sv, rv, tv;
  erm_pkg::out_t  out_r, out_nxt, pend_r, pend_nxt, res;
  logic           out_valid_r, out_valid_nxt, pend_v_r, pend_v_nxt;
  logic [15:0]    cool_r;
  logic [AW-1:0]  act_r, act_nxt;
  logic [KW-1:0]  k_r, k_nxt;
  logic [2:0]     ev_r;
  logic [7:0]     node_r;
  logic [31:0]    now_r, diff;
  logic           sw_op_r;
  logic [RULE_SLOTS-1:0] tok, seen, claim, sel;
  logic [SW-1:0]  tok_idx, add_idx, qdata;
  logic [6:0]     slot_ext;
  logic           slot_ok, accept, hit, scan_end;
  logic           push, pop, qfull, qempty;

  assign accept   = start && !busy;
  assign busy     = (state_r != erm_pkg::FSM_IDLE);
  assign slot_ext = {3'b000, in_data.slot_index};
  assign slot_ok  = (slot_ext < 7'(RULE_SLOTS));

  // cell row
  for (genvar i = 0; i < RULE_SLOTS; i++) begin : g_cell
    assign sel[i] = (slot_ext == 7'(i));
    erm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .sel      (sel[i]),
      .tok_in   ((i == 0) ? cmd.launch : tok[(i == 0) ? 0 : i - 1]),
      .seen_in  ((i == 0) ? 1'b0 : seen[(i == 0) ? 0 : i - 1]),
      .tok      (tok[i]),
      .seen_out (seen[i]),
      .claim    (claim[i]),
      .view     (views[i])
    );
  end

  erm_fifo #(.DEPTH(QUEUE_DEPTH), .W(SW)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (tok_idx),
    .pop       (pop),
    .pop_data  (qdata),
    .full      (qfull),
    .empty     (qempty)
  );

  // selection muxes: token cell, addressed cell, popped cell
  always_comb begin
    sv      = '0;
    rv      = '0;
    tv      = '0;
    tok_idx = '0;
    add_idx = '0;
    for (int i = 0; i < RULE_SLOTS; i++) begin
      if (tok[i]) begin
        sv      = sv | views[i];
        tok_idx = tok_idx | SW'(i);
      end
      if (claim[i]) add_idx = add_idx | SW'(i);
      if (sel[i]) rv = rv | views[i];
      if (qdata == SW'(i)) tv = tv | views[i];
    end
  end

  // match and cooldown of the token cell
  always_comb begin
    logic m;
    m = 1'b0;
    if (sw_op_r) begin
      m = (sv.trig == ((ev_r != 3'd0) ? erm_pkg::TRG_SW_ON : erm_pkg::TRG_SW_OFF));
    end else begin
      unique case (sv.trig)
        erm_pkg::TRG_ACTIVE:   m = (ev_r == erm_pkg::EV_ACTIVE);
        erm_pkg::TRG_ALERT:    m = (ev_r == erm_pkg::EV_ALERT) || (ev_r == erm_pkg::EV_CRITICAL);
        erm_pkg::TRG_CRITICAL: m = (ev_r == erm_pkg::EV_CRITICAL);
        erm_pkg::TRG_IDLE:     m = (ev_r == erm_pkg::EV_IDLE);
        erm_pkg::TRG_LOST:     m = (ev_r == erm_pkg::EV_LOST);
        default:               m = 1'b0;
      endcase
    end
    hit  = (state_r == erm_pkg::FSM_SCAN) && sv.valid && (sv.node == node_r) && m;
    diff = now_r - sv.last;
  end

  assign scan_end = tok[RULE_SLOTS-1] ||
                    (hit && (k_r + 1'b1 == KW'(erm_pkg::RESULT_LIMIT)));

  // control, result formation
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.node      = in_data.new_node;
    cmd.trig      = in_data.new_trigger;
    cmd.act       = in_data.new_action;
    cmd.cnt       = in_data.new_target_count;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    pend_nxt      = pend_r;
    pend_v_nxt    = pend_v_r;
    act_nxt       = act_r;
    k_nxt         = k_r;
    push          = 1'b0;
    pop           = 1'b0;
    res           = '0;
    unique case (state_r)
      erm_pkg::FSM_IDLE: begin
        if (accept) begin
          res.last_result = 1'b1;
          out_valid_nxt   = 1'b1;
          priority case (in_data.operation)
            erm_pkg::OP_ADD: begin
              if (in_data.new_target_count == 4'd0 ||
                  32'(in_data.new_target_count) > 32'(MAX_TARGETS)) begin
                res.status = erm_pkg::ST_INVALID;
              end else if (!seen[RULE_SLOTS-1]) begin
                res.status = erm_pkg::ST_FULL;
              end else begin
                cmd.add_en            = 1'b1;
                act_nxt               = act_r + 1'b1;
                res.status            = erm_pkg::ST_ADDED;
                res.rule_slot         = 4'(add_idx);
                res.rule_node         = in_data.new_node;
                res.rule_trigger      = in_data.new_trigger;
                res.rule_action       = in_data.new_action;
                res.rule_target_count = in_data.new_target_count;
              end
            end
            erm_pkg::OP_REMOVE: begin
              res.rule_slot = in_data.slot_index;
              if (!slot_ok) begin
                res.status = erm_pkg::ST_INVALID;
              end else begin
                cmd.rm_en  = 1'b1;
                act_nxt    = act_r - AW'(rv.valid);
                res.status = erm_pkg::ST_REMOVED;
              end
            end
            erm_pkg::OP_READ: begin
              res.rule_slot = in_data.slot_index;
              if (slot_ok && rv.valid) begin
                res.status            = erm_pkg::ST_READ_OK;
                res.rule_node         = rv.node;
                res.rule_trigger      = rv.trig;
                res.rule_action       = rv.act;
                res.rule_target_count = rv.cnt;
              end else begin
                res.status = erm_pkg::ST_READ_NONE;
              end
            end
            erm_pkg::OP_STATE, erm_pkg::OP_SWITCH: begin
              if (!in_data.node_known) begin
                res.status = erm_pkg::ST_UNKNOWN;
              end else begin
                out_valid_nxt = 1'b0;
                cmd.launch    = 1'b1;
                cmd.shift     = 1'b1;
                pend_v_nxt    = 1'b0;
                k_nxt         = '0;
                state_nxt     = erm_pkg::FSM_SCAN;
              end
            end
            erm_pkg::OP_TAKE: begin
              if (qempty) begin
                res.status = erm_pkg::ST_QEMPTY;
              end else begin
                pop           = 1'b1;
                res.rule_slot = 4'(qdata);
                if (tv.valid) begin
                  res.status            = erm_pkg::ST_FIRED;
                  res.rule_node         = tv.node;
                  res.rule_trigger      = tv.trig;
                  res.rule_action       = tv.act;
                  res.rule_target_count = tv.cnt;
                end else begin
                  res.status = erm_pkg::ST_VANISHED;
                end
              end
            end
            default: res.status = erm_pkg::ST_INVALID;
          endcase
          res.active_rules = 5'(act_nxt);
          out_nxt          = res;
        end
      end
      erm_pkg::FSM_SCAN: begin
        cmd.shift = !scan_end;
        if (hit) begin
          res.rule_slot         = 4'(tok_idx);
          res.rule_node         = sv.node;
          res.rule_trigger      = sv.trig;
          res.rule_action       = sv.act;
          res.rule_target_count = sv.cnt;
          res.active_rules      = 5'(act_r);
          if (diff < {16'h0000, cool_r}) begin
            res.status = erm_pkg::ST_SKIP;
          end else if (qfull) begin
            cmd.stamp_en  = 1'b1;
            cmd.stamp_val = '0;
            res.status    = erm_pkg::ST_QFULL;
          end else begin
            cmd.stamp_en  = 1'b1;
            cmd.stamp_val = now_r;
            push          = 1'b1;
            res.status    = erm_pkg::ST_QUEUED;
          end
          // hold one result back so the last one can be flagged
          if (pend_v_r) begin
            out_valid_nxt = 1'b1;
            out_nxt       = pend_r;
          end
          pend_nxt   = res;
          pend_v_nxt = 1'b1;
          k_nxt      = k_r + 1'b1;
        end
        if (scan_end) state_nxt = erm_pkg::FSM_FLUSH;
      end
      erm_pkg::FSM_FLUSH: begin
        out_valid_nxt = 1'b1;
        if (pend_v_r) begin
          out_nxt = pend_r;
        end else begin
          res.status       = erm_pkg::ST_NO_MATCH;
          res.active_rules = 5'(act_r);
          out_nxt          = res;
        end
        out_nxt.last_result = 1'b1;
        pend_v_nxt          = 1'b0;
        state_nxt           = erm_pkg::FSM_IDLE;
      end
      default: state_nxt = erm_pkg::FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= erm_pkg::FSM_IDLE;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
      act_r       <= '0;
      k_r         <= '0;
      cool_r      <= erm_pkg::COOLDOWN_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pend_v_r    <= pend_v_nxt;
      act_r       <= act_nxt;
      k_r         <= k_nxt;
      if (cfg_we) cool_r <= cfg_wdata;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    pend_r <= pend_nxt;
    if (accept) begin
      ev_r    <= in_data.event_value;
      node_r  <= in_data.node_index;
      now_r   <= in_data.now_ms;
      sw_op_r <= (in_data.operation == erm_pkg::OP_SWITCH);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_tok_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(tok))
    else $error("more than one scan token");
  a_act_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(act_r) <= RULE_SLOTS)
    else $error("active count out of range");
  a_end_flag: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> (out_valid && out_data.last_result))
    else $error("scan ended without a last result");
  a_tok_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == erm_pkg::FSM_IDLE) |-> (tok == '0))
    else $error("token alive while idle");

endmodule

// ----- test/event_rule_match_cooldown_test.sv -----
// ----------------------------------------------------------------------------
// event_rule_match_cooldown_test
// Self-checking bench for the rule table: adds, removes and reads rules,
// sends state and switch events under several cooldown settings, and drains
// the fire queue. Every result beat is checked field by field against a
// local model of the table, the cooldown stamps and the fire queue.
// ----------------------------------------------------------------------------
module event_rule_match_cooldown_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          SLOTS       = 16;
  localparam int          QDEPTH      = 8;
  localparam int          MAXT        = 8;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          SETTLE      = SLOTS + 4;
  localparam int          IN_W        = $bits(erm_pkg::in_t);
  localparam logic [2:0]  OP_SPARE_A  = 3'd6;
  localparam logic [2:0]  OP_SPARE_B  = 3'd7;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           start = 1'b0;
  logic           busy;
  erm_pkg::in_t   in_data = '0;
  logic           out_valid;
  erm_pkg::out_t  out_data;
  logic           cfg_we = 1'b0;
  logic [15:0]    cfg_wdata = '0;

  // Local copy of the table, stamps, queue and cooldown
  logic        tbl_valid [SLOTS];
  logic [7:0]  tbl_node  [SLOTS];
  logic [2:0]  tbl_trig  [SLOTS];
  logic [1:0]  tbl_act   [SLOTS];
  logic [3:0]  tbl_cnt   [SLOTS];
  logic [31:0] tbl_stamp [SLOTS];
  logic [3:0]  fire_fifo [QDEPTH];
  int          fifo_head, fifo_tail, fifo_fill;
  logic [15:0] cooldown;

  erm_pkg::out_t pending_beats[$];
  int            errors = 0;
  int            items_sent = 0;
  int            beats_checked = 0;
  int            cycles = 0;
  logic [31:0]   clock_ms = 32'd0;

  event_rule_match_cooldown u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Model of the block
  // ------------------------------------------------------------------------
  function automatic logic state_hit(logic [2:0] trig, logic [2:0] ev);
    case (trig)
      erm_pkg::TRG_ACTIVE:   return ev == erm_pkg::EV_ACTIVE;
      erm_pkg::TRG_ALERT:    return ev == erm_pkg::EV_ALERT || ev == erm_pkg::EV_CRITICAL;
      erm_pkg::TRG_CRITICAL: return ev == erm_pkg::EV_CRITICAL;
      erm_pkg::TRG_IDLE:     return ev == erm_pkg::EV_IDLE;
      erm_pkg::TRG_LOST:     return ev == erm_pkg::EV_LOST;
      default:               return 1'b0;
    endcase
  endfunction

  function automatic erm_pkg::out_t rule_beat(erm_pkg::status_t st, logic [3:0] slot,
                                              logic show);
    erm_pkg::out_t o;
    o = '0;
    o.status    = st;
    o.rule_slot = slot;
    if (show) begin
      o.rule_node         = tbl_node[slot];
      o.rule_trigger      = tbl_trig[slot];
      o.rule_action       = tbl_act[slot];
      o.rule_target_count = tbl_cnt[slot];
    end
    return o;
  endfunction

  task automatic model_reset();
    for (int i = 0; i < SLOTS; i++) begin
      tbl_valid[i] = 1'b0; tbl_node[i] = '0; tbl_trig[i] = '0;
      tbl_act[i] = '0; tbl_cnt[i] = '0; tbl_stamp[i] = '0;
    end
    fifo_head = 0; fifo_tail = 0; fifo_fill = 0;
    cooldown = erm_pkg::COOLDOWN_RESET;
  endtask

  // Work out the result beats of one accepted item and queue them
  task automatic predict_beats(input erm_pkg::in_t it);
    erm_pkg::out_t beats[$];
    int   free_slot;
    int   s;
    int   act_cnt;
    logic hit;
    logic [2:0] sw_trig;
    free_slot = -1;
    act_cnt = 0;
    case (it.operation)
      erm_pkg::OP_ADD: begin
        if (it.new_target_count == 0 || it.new_target_count > MAXT) begin
          beats.push_back(rule_beat(erm_pkg::ST_INVALID, 4'd0, 1'b0));
        end else begin
          for (int i = SLOTS - 1; i >= 0; i--)
            if (!tbl_valid[i]) free_slot = i;
          if (free_slot < 0) begin
            beats.push_back(rule_beat(erm_pkg::ST_FULL, 4'd0, 1'b0));
          end else begin
            tbl_valid[free_slot] = 1'b1;
            tbl_node[free_slot]  = it.new_node;
            tbl_trig[free_slot]  = it.new_trigger;
            tbl_act[free_slot]   = it.new_action;
            tbl_cnt[free_slot]   = it.new_target_count;
            beats.push_back(rule_beat(erm_pkg::ST_ADDED, free_slot[3:0], 1'b1));
          end
        end
      end
      erm_pkg::OP_REMOVE: begin
        tbl_valid[it.slot_index] = 1'b0; tbl_node[it.slot_index] = '0;
        tbl_trig[it.slot_index] = '0; tbl_act[it.slot_index] = '0;
        tbl_cnt[it.slot_index] = '0; tbl_stamp[it.slot_index] = '0;
        beats.push_back(rule_beat(erm_pkg::ST_REMOVED, it.slot_index, 1'b0));
      end
      erm_pkg::OP_READ: begin
        if (tbl_valid[it.slot_index])
          beats.push_back(rule_beat(erm_pkg::ST_READ_OK, it.slot_index, 1'b1));
        else
          beats.push_back(rule_beat(erm_pkg::ST_READ_NONE, it.slot_index, 1'b0));
      end
      erm_pkg::OP_STATE, erm_pkg::OP_SWITCH: begin
        if (!it.node_known) begin
          beats.push_back(rule_beat(erm_pkg::ST_UNKNOWN, 4'd0, 1'b0));
        end else begin
          sw_trig = (it.event_value != 0) ? erm_pkg::TRG_SW_ON : erm_pkg::TRG_SW_OFF;
          for (int i = 0; i < SLOTS && beats.size() < erm_pkg::RESULT_LIMIT; i++) begin
            if (it.operation == erm_pkg::OP_STATE)
              hit = state_hit(tbl_trig[i], it.event_value);
            else
              hit = (tbl_trig[i] == sw_trig);
            if (tbl_valid[i] && tbl_node[i] == it.node_index && hit) begin
              if (it.now_ms - tbl_stamp[i] < {16'd0, cooldown}) begin
                beats.push_back(rule_beat(erm_pkg::ST_SKIP, i[3:0], 1'b1));
              end else if (fifo_fill < QDEPTH) begin
                tbl_stamp[i] = it.now_ms;
                fire_fifo[fifo_tail] = i[3:0];
                fifo_tail = (fifo_tail + 1) % QDEPTH;
                fifo_fill++;
                beats.push_back(rule_beat(erm_pkg::ST_QUEUED, i[3:0], 1'b1));
              end else begin
                // stamp rolls back to zero when the queue is full
                tbl_stamp[i] = '0;
                beats.push_back(rule_beat(erm_pkg::ST_QFULL, i[3:0], 1'b1));
              end
            end
          end
          if (beats.size() == 0)
            beats.push_back(rule_beat(erm_pkg::ST_NO_MATCH, 4'd0, 1'b0));
        end
      end
      erm_pkg::OP_TAKE: begin
        if (fifo_fill == 0) begin
          beats.push_back(rule_beat(erm_pkg::ST_QEMPTY, 4'd0, 1'b0));
        end else begin
          s = int'(fire_fifo[fifo_head]);
          fifo_head = (fifo_head + 1) % QDEPTH;
          fifo_fill--;
          if (tbl_valid[s]) beats.push_back(rule_beat(erm_pkg::ST_FIRED, s[3:0], 1'b1));
          else beats.push_back(rule_beat(erm_pkg::ST_VANISHED, s[3:0], 1'b0));
        end
      end
      default: beats.push_back(rule_beat(erm_pkg::ST_INVALID, 4'd0, 1'b0));
    endcase
    for (int i = 0; i < SLOTS; i++) act_cnt += int'(tbl_valid[i]);
    foreach (beats[j]) begin
      beats[j].active_rules = act_cnt[4:0];
      beats[j].last_result  = (j == beats.size() - 1);
      pending_beats.push_back(beats[j]);
    end
  endtask

  // ------------------------------------------------------------------------
  // Result checker
  // ------------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] exp_v,
                                      logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    erm_pkg::out_t want;
    if (rst_n && out_valid) begin
      if (pending_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, got %h", $realtime, out_data);
      end else begin
        want = pending_beats.pop_front();
        beats_checked++;
        check_field("status", 32'(want.status), 32'(out_data.status));
        check_field("rule_slot", 32'(want.rule_slot), 32'(out_data.rule_slot));
        check_field("rule_node", 32'(want.rule_node), 32'(out_data.rule_node));
        check_field("rule_trigger", 32'(want.rule_trigger), 32'(out_data.rule_trigger));
        check_field("rule_action", 32'(want.rule_action), 32'(out_data.rule_action));
        check_field("rule_target_count", 32'(want.rule_target_count),
                    32'(out_data.rule_target_count));
        check_field("active_rules", 32'(want.active_rules), 32'(out_data.active_rules));
        check_field("last_result", 32'(want.last_result), 32'(out_data.last_result));
      end
    end
  end

  // ------------------------------------------------------------------------
  // Driving helpers
  // ------------------------------------------------------------------------
  // Present one item and hold it until the block takes it
  task automatic send_item(input erm_pkg::in_t it);
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    items_sent++;
    predict_beats(it);
  endtask

  // Lower start, wait for all beats and let the scan settle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cooldown(input logic [15:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cooldown = value;
  endtask

  function automatic erm_pkg::in_t add_item(logic [7:0] node, logic [2:0] trig,
                                            logic [1:0] act, logic [3:0] cnt);
    erm_pkg::in_t it;
    it = '0;
    it.operation = erm_pkg::OP_ADD; it.new_node = node; it.new_trigger = trig;
    it.new_action = act; it.new_target_count = cnt;
    return it;
  endfunction

  function automatic erm_pkg::in_t event_item(logic [2:0] op, logic [7:0] node,
                                              logic known, logic [2:0] ev,
                                              logic [31:0] now);
    erm_pkg::in_t it;
    it = '0;
    it.operation = op; it.node_index = node; it.node_known = known;
    it.event_value = ev; it.now_ms = now;
    return it;
  endfunction

  function automatic erm_pkg::in_t slot_item(logic [2:0] op, logic [3:0] slot);
    erm_pkg::in_t it;
    it = '0;
    it.operation = op; it.slot_index = slot;
    return it;
  endfunction

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------
  // Table access, alert, critical and switch matching and the reset cooldown of 100 ms
  task automatic test_rules_and_matching();
    send_item(add_item(8'd5, erm_pkg::TRG_ALERT, 2'd0, 4'd0));     // count zero
    send_item(add_item(8'd255, 3'd7, 2'd3, 4'd15));                // count too big
    send_item(add_item(8'd5, erm_pkg::TRG_ALERT, 2'd0, 4'd8));
    send_item(add_item(8'd5, erm_pkg::TRG_CRITICAL, 2'd1, 4'd1));
    send_item(add_item(8'd5, erm_pkg::TRG_SW_ON, 2'd2, 4'd3));
    send_item(add_item(8'd5, erm_pkg::TRG_SW_OFF, 2'd3, 4'd2));
    // below cooldown right after reset: both skipped
    send_item(event_item(erm_pkg::OP_STATE, 8'd5, 1'b1, erm_pkg::EV_CRITICAL, 32'd50));
    send_item(event_item(erm_pkg::OP_STATE, 8'd5, 1'b1, erm_pkg::EV_CRITICAL, 32'd1000));
    send_item(event_item(erm_pkg::OP_STATE, 8'd5, 1'b1, erm_pkg::EV_ALERT, 32'd1050));
    send_item(event_item(erm_pkg::OP_SWITCH, 8'd5, 1'b1, 3'd7, 32'd2000));
    send_item(event_item(erm_pkg::OP_SWITCH, 8'd5, 1'b1, 3'd0, 32'd2000));
    send_item(event_item(erm_pkg::OP_STATE, 8'd5, 1'b1, 3'd5, 32'hFFFF_FFFF));
    send_item(event_item(erm_pkg::OP_STATE, 8'd255, 1'b0, erm_pkg::EV_ALERT, 32'd3000));
    send_item(slot_item(erm_pkg::OP_READ, 4'd0));
    send_item(slot_item(erm_pkg::OP_READ, 4'd15));
    send_item(slot_item(erm_pkg::OP_REMOVE, 4'd1));
    // fired, vanished, fired, fired
    repeat (4) send_item(slot_item(erm_pkg::OP_TAKE, 4'd0));
    send_item(slot_item(erm_pkg::OP_TAKE, 4'd0));                  // queue empty
    send_item(slot_item(OP_SPARE_A, 4'd15));
    send_item(slot_item(OP_SPARE_B, 4'd0));
  endtask

  // Zero cooldown: one rule set fills the queue, every hit passes the cooldown
  task automatic test_queue_full();
    write_cooldown(16'd0);
    for (int i = 0; i < 3; i++)
      send_item(add_item(8'd7, erm_pkg::TRG_LOST, i[1:0], 4'd4));
    for (int i = 0; i < 3; i++)
      send_item(event_item(erm_pkg::OP_STATE, 8'd7, 1'b1, erm_pkg::EV_LOST, 32'd0));
    repeat (QDEPTH) send_item(slot_item(erm_pkg::OP_TAKE, 4'd0));
  endtask

  function automatic erm_pkg::in_t random_item();
    erm_pkg::in_t it;
    int           pick;
    it = erm_pkg::in_t'(IN_W'({$urandom, $urandom, $urandom}));
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0) clock_ms = $urandom;
    else clock_ms += $urandom_range(0, 2 * cooldown + 5);
    it.now_ms = clock_ms;
    it.node_known = ($urandom_range(0, 15) != 0);
    if ($urandom_range(0, 7) != 0) begin
      it.node_index = 8'($urandom_range(0, 3));
      it.new_node   = 8'($urandom_range(0, 3));
    end
    if ($urandom_range(0, 7) != 0) it.new_target_count = 4'($urandom_range(1, MAXT));
    if (pick < 20)      it.operation = erm_pkg::OP_ADD;
    else if (pick < 28) it.operation = erm_pkg::OP_REMOVE;
    else if (pick < 35) it.operation = erm_pkg::OP_READ;
    else if (pick < 62) it.operation = erm_pkg::OP_STATE;
    else if (pick < 75) it.operation = erm_pkg::OP_SWITCH;
    else if (pick < 96) it.operation = erm_pkg::OP_TAKE;
    return it;
  endfunction

  // Random bursts with random gaps under one cooldown setting
  task automatic test_random(input logic [15:0] cool, input int count);
    int sent;
    int burst;
    write_cooldown(cool);
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 8);
      for (int i = 0; i < burst && sent < count; i++) begin
        send_item(random_item());
        sent++;
      end
      if ($urandom_range(0, 2) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 25)) @(posedge clk);
      end
    end
  endtask

  initial begin
    model_reset();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_rules_and_matching();
    test_queue_full();
    test_random(16'd100, 35);
    test_random(16'd0, 35);
    test_random(16'hFFFF, 35);
    test_random(16'($urandom_range(1, 3000)), 35);
    drain();
    $display("Covered table add/remove/read, state and switch matching, cooldown");
    $display("settings 0..65535 and queue overflow: %0d items, %0d beats checked",
             items_sent, beats_checked);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- event_rule_match_cooldown.f -----
rtl/erm_pkg.sv
rtl/erm_cell.sv
rtl/erm_fifo.sv
rtl/event_rule_match_cooldown.sv
test/event_rule_match_cooldown_test.sv
